### hw/rtl/rme_pkg.sv
// Shared types, opcodes and the control-store program of the register machine executor.
package rme_pkg;

  // Fixed field widths of the stream items.
  localparam int unsigned OP_W      = 5;
  localparam int unsigned DEST_W    = 4;
  localparam int unsigned OPERAND_W = 32;
  localparam int unsigned STEP_W    = 33;
  localparam int unsigned RV_W      = 32;
  localparam int unsigned UPC_W     = 4;

  // Opcodes that the decoder tells apart; all others behave as no-ops.
  localparam logic [OP_W-1:0] OP_ADD  = 5'd0;
  localparam logic [OP_W-1:0] OP_ADDC = 5'd1;
  localparam logic [OP_W-1:0] OP_DIV  = 5'd2;
  localparam logic [OP_W-1:0] OP_DIVC = 5'd3;
  localparam logic [OP_W-1:0] OP_EQ   = 5'd4;
  localparam logic [OP_W-1:0] OP_EQC  = 5'd5;
  localparam logic [OP_W-1:0] OP_JMP  = 5'd6;
  localparam logic [OP_W-1:0] OP_JMPC = 5'd7;
  localparam logic [OP_W-1:0] OP_MOD  = 5'd8;
  localparam logic [OP_W-1:0] OP_MODC = 5'd9;
  localparam logic [OP_W-1:0] OP_MUL  = 5'd10;
  localparam logic [OP_W-1:0] OP_MULC = 5'd11;
  localparam logic [OP_W-1:0] OP_RET  = 5'd15;
  localparam logic [OP_W-1:0] OP_RETC = 5'd16;
  localparam logic [OP_W-1:0] OP_SET  = 5'd17;
  localparam logic [OP_W-1:0] OP_SETC = 5'd18;

  // Program counter offsets.
  localparam logic [STEP_W-1:0] STEP_NONE = 33'd0;
  localparam logic [STEP_W-1:0] STEP_ONE  = 33'd1;
  localparam logic [STEP_W-1:0] STEP_SKIP = 33'd2;

  // Operation classes after decode.
  typedef enum logic [3:0] {
    CL_NOP = 4'd0,
    CL_ADD = 4'd1,
    CL_DIV = 4'd2,
    CL_MOD = 4'd3,
    CL_MUL = 4'd4,
    CL_EQ  = 4'd5,
    CL_JMP = 4'd6,
    CL_RET = 4'd7,
    CL_SET = 4'd8
  } op_class_e;

  // How the sequencer picks its next step.
  typedef enum logic [2:0] {
    SQ_NEXT     = 3'd0,
    SQ_WAIT_IN  = 3'd1,
    SQ_DISPATCH = 3'd2,
    SQ_WAIT_IU  = 3'd3,
    SQ_WAIT_OUT = 3'd4
  } seq_e;

  // Register file read address select.
  typedef enum logic {
    RD_DEST = 1'b0,
    RD_SRC  = 1'b1
  } rd_sel_e;

  // One control word of the program.
  typedef struct packed {
    seq_e       seq;
    logic       idx_en;
    logic       idx_first;
    logic [1:0] idx_chunk;
    rd_sel_e    rd_sel;
    logic       ld_left;
    logic       ld_right;
    logic       iu_start;
    logic       wb_en;
    logic       emit;
  } uc_word_t;

  // Control and status between the sequencer and the iterative unit.
  typedef struct packed {
    logic start;
    logic mul;
  } iu_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iu_stat_t;

  // Program addresses.
  localparam logic [UPC_W-1:0] UA_FETCH = 4'd0;
  localparam logic [UPC_W-1:0] UA_IDX0  = 4'd1;
  localparam logic [UPC_W-1:0] UA_IDX1  = 4'd2;
  localparam logic [UPC_W-1:0] UA_IDX2  = 4'd3;
  localparam logic [UPC_W-1:0] UA_IDX3  = 4'd4;
  localparam logic [UPC_W-1:0] UA_RDL   = 4'd5;
  localparam logic [UPC_W-1:0] UA_RDR   = 4'd6;
  localparam logic [UPC_W-1:0] UA_LDR   = 4'd7;
  localparam logic [UPC_W-1:0] UA_ITER  = 4'd8;
  localparam logic [UPC_W-1:0] UA_IWAIT = 4'd9;
  localparam logic [UPC_W-1:0] UA_WB    = 4'd10;
  localparam logic [UPC_W-1:0] UA_EMIT  = 4'd11;

  // Decode an opcode into its class.
  function automatic op_class_e op_class(input logic [OP_W-1:0] op);
    op_class_e cls;
    case (op)
      OP_ADD, OP_ADDC: cls = CL_ADD;
      OP_DIV, OP_DIVC: cls = CL_DIV;
      OP_EQ,  OP_EQC:  cls = CL_EQ;
      OP_JMP, OP_JMPC: cls = CL_JMP;
      OP_MOD, OP_MODC: cls = CL_MOD;
      OP_MUL, OP_MULC: cls = CL_MUL;
      OP_RET, OP_RETC: cls = CL_RET;
      OP_SET, OP_SETC: cls = CL_SET;
      default:         cls = CL_NOP;
    endcase
    return cls;
  endfunction

  // True when the operand is an immediate rather than a register index.
  function automatic logic op_is_imm(input logic [OP_W-1:0] op);
    logic imm;
    case (op)
      OP_ADDC, OP_DIVC, OP_EQC, OP_JMPC,
      OP_MODC, OP_MULC, OP_RETC, OP_SETC: imm = 1'b1;
      default:                            imm = 1'b0;
    endcase
    return imm;
  endfunction

  // Entry step of each class after both operands are loaded.
  function automatic logic [UPC_W-1:0] dispatch_target(input op_class_e cls);
    logic [UPC_W-1:0] tgt;
    case (cls)
      CL_ADD, CL_SET:         tgt = UA_WB;
      CL_DIV, CL_MOD, CL_MUL: tgt = UA_ITER;
      default:                tgt = UA_EMIT;
    endcase
    return tgt;
  endfunction

  // The control store.
  function automatic uc_word_t uc_rom(input logic [UPC_W-1:0] addr);
    uc_word_t w;
    w     = '0;
    w.seq = SQ_NEXT;
    case (addr)
      UA_FETCH: w.seq = SQ_WAIT_IN;
      UA_IDX0: begin
        w.idx_en    = 1'b1;
        w.idx_first = 1'b1;
        w.idx_chunk = 2'd3;
      end
      UA_IDX1: begin
        w.idx_en    = 1'b1;
        w.idx_chunk = 2'd2;
      end
      UA_IDX2: begin
        w.idx_en    = 1'b1;
        w.idx_chunk = 2'd1;
      end
      UA_IDX3: begin
        w.idx_en    = 1'b1;
        w.idx_chunk = 2'd0;
      end
      UA_RDL: w.rd_sel = RD_DEST;
      UA_RDR: begin
        w.rd_sel  = RD_SRC;
        w.ld_left = 1'b1;
      end
      UA_LDR: begin
        w.ld_right = 1'b1;
        w.seq      = SQ_DISPATCH;
      end
      UA_ITER:  w.iu_start = 1'b1;
      UA_IWAIT: w.seq = SQ_WAIT_IU;
      UA_WB:    w.wb_en = 1'b1;
      UA_EMIT: begin
        w.emit = 1'b1;
        w.seq  = SQ_WAIT_OUT;
      end
      default: w.seq = SQ_WAIT_IN;
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/rme_iter_unit.sv
// Bit-serial unit that divides (restoring) or multiplies, one bit per cycle.
module rme_iter_unit #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rme_pkg::iu_ctrl_t     ctrl_i,
  input  logic [DATA_WIDTH-1:0] a_i,
  input  logic [DATA_WIDTH-1:0] b_i,
  output rme_pkg::iu_stat_t     stat_o,
  output logic [DATA_WIDTH-1:0] quo_o,
  output logic [DATA_WIDTH-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(DATA_WIDTH);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  mul_q;
  logic [DATA_WIDTH-1:0] opnd_q;
  logic [DATA_WIDTH-1:0] quo_q;
  logic [DATA_WIDTH-1:0] rem_q;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   diff;
  logic [DATA_WIDTH-1:0] acc;

  // One restoring-division step and one shift-and-add step.
  always_comb begin
    shifted = {rem_q, quo_q[DATA_WIDTH-1]};
    diff    = shifted - {1'b0, opnd_q};
    acc     = {rem_q[DATA_WIDTH-2:0], 1'b0} + (quo_q[DATA_WIDTH-1] ? opnd_q : '0);
  end

  // Iteration control.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DATA_WIDTH - 1);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath: the quotient register also shifts out the dividend or multiplier.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      mul_q  <= ctrl_i.mul;
      opnd_q <= ctrl_i.mul ? a_i : b_i;
      quo_q  <= ctrl_i.mul ? b_i : a_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      if (mul_q) begin
        rem_q <= acc;
        quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b0};
      end else begin
        rem_q <= diff[DATA_WIDTH] ? shifted[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
        quo_q <= {quo_q[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;
  assign rem_o       = rem_q;

  // A new start never lands on a running iteration.
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |-> !busy_q)
    else $error("iteration started while busy");

  // Start always begins a run.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |=> busy_q)
    else $error("start did not set busy");

  // Completion is flagged only after the last step.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (!busy_q && $past(busy_q)))
    else $error("done raised outside the end of a run");

endmodule

### hw/rtl/register_machine_executor_core.sv
// Top level of the register machine executor: control-store sequencer and datapath.
//
// One instruction enters on the slave stream per beat: tuser carries the opcode,
// tdata the destination index and the operand. For each instruction exactly one
// result beat leaves on the master stream with the program counter offset and
// the return value in tdata and the halt flag in tuser.
// A small control store steps a plain datapath: four steps reduce the operand to
// a register index (eight bits per step), three steps read the register file
// through its single registered read port, then the class of the operation
// selects write back, the bit-serial unit, or the result step.
// One instruction is in work at a time; the core is ready for the next beat in
// the cycle after the result is registered. The bit-serial unit takes one bit
// per cycle for divide, modulo and multiply.
// Reset clears the sequencer, the output valid flag and every register's valid
// bit, so all registers read as zero; no clearing pass is needed.
// A stalled receiver holds the result in the output register; the following
// instruction is accepted and worked on, then waits at its result step.
module register_machine_executor_core #(
  parameter int unsigned NUM_REGS   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // dest_index[3:0], operand[35:4], zero fill
  input  logic [4:0]  s_axis_tuser,  // operation[4:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // pc_step[32:0], return_value[64:33], zero fill
  output logic        m_axis_tuser   // halted
);

  localparam int unsigned IW = $clog2(NUM_REGS);
  localparam logic [IW:0] IDX_N = (IW + 1)'(NUM_REGS);
  localparam int unsigned JW = (DATA_WIDTH > rme_pkg::STEP_W) ? DATA_WIDTH + 1
                                                              : rme_pkg::STEP_W + 1;

  // Reduce a running remainder by eight more operand bits, MSB first.
  function automatic logic [IW-1:0] mod_byte(input logic [IW-1:0] rem,
                                             input logic [7:0] chunk);
    logic [IW:0]   t;
    logic [IW-1:0] r;
    r = rem;
    for (int i = 7; i >= 0; i--) begin
      t = {r, chunk[i]};
      if (t >= IDX_N) begin
        t = t - IDX_N;
      end
      r = t[IW-1:0];
    end
    return r;
  endfunction

  logic [rme_pkg::UPC_W-1:0]     upc_q, upc_d;
  rme_pkg::uc_word_t             uc;
  rme_pkg::op_class_e            cls;
  logic                          is_imm;
  logic                          in_fire;
  logic                          out_free;
  logic                          emit_fire;

  logic [rme_pkg::OP_W-1:0]      op_q;
  logic [rme_pkg::DEST_W-1:0]    dest_raw_q;
  logic [rme_pkg::OPERAND_W-1:0] operand_q;
  logic [IW-1:0]                 d_q;
  logic [IW-1:0]                 s_q;
  logic [7:0]                    chunk;

  logic [DATA_WIDTH-1:0]         mem_q [NUM_REGS];
  logic [NUM_REGS-1:0]           vld_q;
  logic [IW-1:0]                 rd_addr;
  logic [DATA_WIDTH-1:0]         rd_data_q;
  logic                          rd_vld_q;
  logic [DATA_WIDTH-1:0]         rd_eff;
  logic [DATA_WIDTH-1:0]         imm;
  logic [DATA_WIDTH-1:0]         left_q;
  logic [DATA_WIDTH-1:0]         right_q;
  logic [DATA_WIDTH-1:0]         wb_val;

  rme_pkg::iu_ctrl_t             iu_ctrl;
  rme_pkg::iu_stat_t             iu_stat;
  logic [DATA_WIDTH-1:0]         iu_quo;
  logic [DATA_WIDTH-1:0]         iu_rem;

  logic [JW-1:0]                 tgt_neg;
  logic [JW-1:0]                 tgt_pos;
  logic [rme_pkg::STEP_W-1:0]    res_step;
  logic                          res_halt;
  logic [rme_pkg::RV_W-1:0]      res_rv;

  logic                          m_valid_q;
  logic [rme_pkg::STEP_W-1:0]    m_step_q;
  logic                          m_halt_q;
  logic [rme_pkg::RV_W-1:0]      m_rv_q;

  // Control word and decode of the held instruction.
  assign uc     = rme_pkg::uc_rom(upc_q);
  assign cls    = rme_pkg::op_class(op_q);
  assign is_imm = rme_pkg::op_is_imm(op_q);

  assign s_axis_tready = (uc.seq == rme_pkg::SQ_WAIT_IN);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign emit_fire     = uc.emit && out_free;

  // Sequencer: step counter with waits and the class dispatch.
  always_comb begin
    upc_d = upc_q;
    case (uc.seq)
      rme_pkg::SQ_NEXT:     upc_d = upc_q + 1'b1;
      rme_pkg::SQ_WAIT_IN:  upc_d = in_fire ? rme_pkg::UA_IDX0 : upc_q;
      rme_pkg::SQ_DISPATCH: upc_d = rme_pkg::dispatch_target(cls);
      rme_pkg::SQ_WAIT_IU:  upc_d = iu_stat.done ? upc_q + 1'b1 : upc_q;
      rme_pkg::SQ_WAIT_OUT: upc_d = out_free ? rme_pkg::UA_FETCH : upc_q;
      default:              upc_d = rme_pkg::UA_FETCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= rme_pkg::UA_FETCH;
    end else begin
      upc_q <= upc_d;
    end
  end

  // Instruction capture and index reduction.
  assign chunk = operand_q[{uc.idx_chunk, 3'b000} +: 8];

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q       <= s_axis_tuser;
      dest_raw_q <= s_axis_tdata[3:0];
      operand_q  <= s_axis_tdata[35:4];
    end
    if (uc.idx_en) begin
      if (uc.idx_first) begin
        s_q <= mod_byte('0, chunk);
        d_q <= mod_byte('0, {4'b0000, dest_raw_q});
      end else begin
        s_q <= mod_byte(s_q, chunk);
      end
    end
  end

  // Register file: one write port, one registered read port.
  assign rd_addr = (uc.rd_sel == rme_pkg::RD_DEST) ? d_q : s_q;

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr];
    if (uc.wb_en) begin
      mem_q[d_q] <= wb_val;
    end
  end

  // Valid bits make unwritten registers read as zero after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[rd_addr];
      if (uc.wb_en) begin
        vld_q[d_q] <= 1'b1;
      end
    end
  end

  assign rd_eff = rd_vld_q ? rd_data_q : '0;
  assign imm    = DATA_WIDTH'(operand_q);

  // Operand latches.
  always_ff @(posedge clk_i) begin
    if (uc.ld_left) begin
      left_q <= rd_eff;
    end
    if (uc.ld_right) begin
      right_q <= is_imm ? imm : rd_eff;
    end
  end

  // Divide, modulo and multiply share the bit-serial unit.
  assign iu_ctrl.start = uc.iu_start;
  assign iu_ctrl.mul   = (cls == rme_pkg::CL_MUL);

  rme_iter_unit #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_iter (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(iu_ctrl),
    .a_i   (left_q),
    .b_i   (right_q),
    .stat_o(iu_stat),
    .quo_o (iu_quo),
    .rem_o (iu_rem)
  );

  // Write-back value; a zero divisor gives all ones or keeps the dividend.
  always_comb begin
    case (cls)
      rme_pkg::CL_ADD: wb_val = left_q + right_q;
      rme_pkg::CL_SET: wb_val = right_q;
      rme_pkg::CL_DIV: wb_val = (right_q == '0) ? '1 : iu_quo;
      rme_pkg::CL_MOD: wb_val = (right_q == '0) ? left_q : iu_rem;
      rme_pkg::CL_MUL: wb_val = iu_rem;
      default:         wb_val = left_q;
    endcase
  end

  // Jump offset: a negative target is used as is, otherwise target plus one.
  assign tgt_neg = JW'($signed(right_q));
  assign tgt_pos = JW'(right_q) + 1'b1;

  // Result fields.
  always_comb begin
    res_step = rme_pkg::STEP_ONE;
    res_halt = 1'b0;
    res_rv   = '0;
    case (cls)
      rme_pkg::CL_EQ: begin
        res_step = (left_q != right_q) ? rme_pkg::STEP_SKIP : rme_pkg::STEP_ONE;
      end
      rme_pkg::CL_JMP: begin
        res_step = right_q[DATA_WIDTH-1] ? tgt_neg[rme_pkg::STEP_W-1:0]
                                         : tgt_pos[rme_pkg::STEP_W-1:0];
      end
      rme_pkg::CL_RET: begin
        res_step = rme_pkg::STEP_NONE;
        res_halt = 1'b1;
        res_rv   = rme_pkg::RV_W'(right_q);
      end
      default: begin
        res_step = rme_pkg::STEP_ONE;
      end
    endcase
  end

  // Output register parts the sequencer from the receiver.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit_fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      m_step_q <= res_step;
      m_halt_q <= res_halt;
      m_rv_q   <= res_rv;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0000000, m_rv_q, m_step_q};
  assign m_axis_tuser  = m_halt_q;

  // A halting result always carries a zero offset.
  a_halt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[32:0] == '0))
    else $error("halt beat with nonzero offset");

  // Only divide, modulo and multiply start the bit-serial unit.
  a_iu_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uc.iu_start |-> (cls == rme_pkg::CL_DIV || cls == rme_pkg::CL_MOD ||
                     cls == rme_pkg::CL_MUL))
    else $error("bit-serial unit started for another class");

  // An accepted instruction goes straight to index reduction.
  a_fetch_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (upc_q == rme_pkg::UA_IDX0))
    else $error("sequencer did not start index reduction");

  // A result load sets the output valid and returns the sequencer to fetch.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |=> (m_valid_q && (upc_q == rme_pkg::UA_FETCH)))
    else $error("result load did not complete");

endmodule

### tb/tb.sv
// Self-checking testbench for the register machine executor core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcodes that the package leaves to the no-op path.
  localparam logic [rme_pkg::OP_W-1:0] OP_NOP     = 5'd12;
  localparam logic [rme_pkg::OP_W-1:0] OP_PRINT   = 5'd13;
  localparam logic [rme_pkg::OP_W-1:0] OP_PRINTC  = 5'd14;
  localparam logic [rme_pkg::OP_W-1:0] OP_UNKNOWN = 5'd19;
  localparam logic [rme_pkg::OP_W-1:0] OP_TOP     = 5'd31;

  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned STALL_LIMIT  = 2000;

  // One expected result beat.
  typedef struct packed {
    logic [rme_pkg::STEP_W-1:0] step;
    logic                       halted;
    logic [rme_pkg::RV_W-1:0]   rv;
  } exec_result_t;

  // Mirrors the register file and keeps the results still owed by the core.
  class instr_scoreboard;
    logic [31:0]  regs [16];
    exec_result_t owed_results [$];
    int unsigned  errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    // Execute one accepted instruction and queue the result it must produce.
    function void note_instruction(logic [rme_pkg::OP_W-1:0] op, logic [3:0] dest,
                                   logic [31:0] operand);
      exec_result_t res;
      logic [31:0]  left;
      logic [31:0]  right;
      left  = regs[dest];
      right = op[0] ? operand : regs[operand[3:0]];
      // Return and set break the odd-means-immediate pattern.
      if (op == rme_pkg::OP_RET || op == rme_pkg::OP_SET) begin
        right = regs[operand[3:0]];
      end else if (op == rme_pkg::OP_RETC || op == rme_pkg::OP_SETC) begin
        right = operand;
      end
      res.step   = rme_pkg::STEP_ONE;
      res.halted = 1'b0;
      res.rv     = '0;
      case (op)
        rme_pkg::OP_ADD, rme_pkg::OP_ADDC: regs[dest] = left + right;
        rme_pkg::OP_DIV, rme_pkg::OP_DIVC: begin
          regs[dest] = (right == 0) ? 32'hFFFF_FFFF : left / right;
        end
        rme_pkg::OP_EQ, rme_pkg::OP_EQC: begin
          if (left != right) res.step = rme_pkg::STEP_SKIP;
        end
        rme_pkg::OP_JMP, rme_pkg::OP_JMPC: begin
          // A negative target is the offset itself, otherwise one past it.
          res.step = right[31] ? {1'b1, right} : {1'b0, right} + rme_pkg::STEP_ONE;
        end
        rme_pkg::OP_MOD, rme_pkg::OP_MODC: begin
          regs[dest] = (right == 0) ? left : left % right;
        end
        rme_pkg::OP_MUL, rme_pkg::OP_MULC: regs[dest] = left * right;
        rme_pkg::OP_RET, rme_pkg::OP_RETC: begin
          res.step   = rme_pkg::STEP_NONE;
          res.halted = 1'b1;
          res.rv     = right;
        end
        rme_pkg::OP_SET, rme_pkg::OP_SETC: regs[dest] = right;
        default: ;
      endcase
      owed_results.push_back(res);
    endfunction

    // Compare a result beat with the oldest expectation.
    function void check_result(logic [rme_pkg::STEP_W-1:0] step, logic halted,
                               logic [rme_pkg::RV_W-1:0] rv);
      exec_result_t exp_res;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result beat: pc_step %h halted %b return_value %h",
                 $time, step, halted, rv);
        errors++;
        return;
      end
      exp_res = owed_results.pop_front();
      if (step !== exp_res.step) begin
        $display("%0t: pc_step mismatch: expected %h, actual %h", $time, exp_res.step, step);
        errors++;
      end
      if (halted !== exp_res.halted) begin
        $display("%0t: halted mismatch: expected %b, actual %b", $time, exp_res.halted,
                 halted);
        errors++;
      end
      if (rv !== exp_res.rv) begin
        $display("%0t: return_value mismatch: expected %h, actual %h", $time, exp_res.rv,
                 rv);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [4:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tuser;

  instr_scoreboard board;
  bit              no_idle;
  int unsigned     idle_cycles;

  register_machine_executor_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock with a 4 ns period.
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Gap length in cycles: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Present one instruction beat after a random gap and wait until it is taken.
  task automatic send_instr(input logic [rme_pkg::OP_W-1:0] op, input logic [3:0] dest,
                            input logic [31:0] operand);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i) s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, operand, dest};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_instruction(op, dest, operand);
  endtask

  // Hold the input side until the core has delivered every owed result.
  task automatic wait_drained();
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Operand value drawn from small indexes, byte values, corner values or the full range.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 5))
      0, 1: return $urandom_range(0, 15);
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'h0000_0000;
          1: return 32'h0000_0001;
          2: return 32'h7FFF_FFFF;
          3: return 32'h8000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      3: return $urandom_range(0, 255);
      default: return $urandom();
    endcase
  endfunction

  // Result side: random back-pressure, independent of the input side.
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        @(negedge clk_i) m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end else if (!m_axis_tready) begin
        @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Check every result beat as it is accepted.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_result(m_axis_tdata[32:0], m_axis_tuser, m_axis_tdata[64:33]);
    end
  end

  // Watchdog on cycles in which neither side moves a beat.
  initial idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Reset, directed cases, random program, then drain and report.
  initial begin
    logic [rme_pkg::OP_W-1:0] op;
    int unsigned              r;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    rst_ni        = 1'b0;
    no_idle       = 1'b0;
    board         = new();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Extreme values, wrap-around and out-of-range register indexes.
    send_instr(rme_pkg::OP_SETC, 4'd1, 32'hFFFF_FFFF);
    send_instr(rme_pkg::OP_SETC, 4'd2, 32'h8000_0000);
    send_instr(rme_pkg::OP_ADD, 4'd1, 32'd2);
    send_instr(rme_pkg::OP_ADDC, 4'd15, 32'hFFFF_FFFF);
    send_instr(rme_pkg::OP_SET, 4'd3, 32'hFFFF_FFF1);
    // Division and modulo by zero, then by a real divisor, then multiplication.
    send_instr(rme_pkg::OP_DIVC, 4'd4, 32'd0);
    send_instr(rme_pkg::OP_DIV, 4'd1, 32'd5);
    send_instr(rme_pkg::OP_MODC, 4'd15, 32'd0);
    send_instr(rme_pkg::OP_MOD, 4'd2, 32'd0);
    send_instr(rme_pkg::OP_SETC, 4'd6, 32'd7);
    send_instr(rme_pkg::OP_DIV, 4'd4, 32'd6);
    send_instr(rme_pkg::OP_MOD, 4'd15, 32'd6);
    send_instr(rme_pkg::OP_MULC, 4'd6, 32'hFFFF_FFFF);
    send_instr(rme_pkg::OP_MUL, 4'd2, 32'd2);
    // Compare hit and miss.
    send_instr(rme_pkg::OP_EQ, 4'd0, 32'd0);
    send_instr(rme_pkg::OP_EQC, 4'd6, 32'd5);
    send_instr(rme_pkg::OP_EQC, 4'd0, 32'd0);
    // Jumps around the sign boundary.
    send_instr(rme_pkg::OP_JMPC, 4'd0, 32'h7FFF_FFFF);
    send_instr(rme_pkg::OP_JMPC, 4'd0, 32'hFFFF_FFFF);
    send_instr(rme_pkg::OP_JMPC, 4'd0, 32'h8000_0000);
    send_instr(rme_pkg::OP_JMP, 4'd0, 32'd3);
    // Returns, print forms, no-op and an undefined opcode.
    send_instr(rme_pkg::OP_RET, 4'd0, 32'h1234_5673);
    send_instr(rme_pkg::OP_RETC, 4'd9, 32'hDEAD_BEEF);
    send_instr(OP_NOP, 4'd5, 32'hA5A5_A5A5);
    send_instr(OP_PRINT, 4'd4, 32'd4);
    send_instr(OP_PRINTC, 4'd8, 32'h5A5A_5A5A);
    send_instr(OP_TOP, 4'd15, 32'hFFFF_FFFF);

    // Random program; immediate sets keep the register contents varied.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_ITEMS / 2) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 4) begin
        op = rme_pkg::OP_W'($urandom_range(OP_UNKNOWN, OP_TOP));
      end else if (r < 16) begin
        op = rme_pkg::OP_SETC;
      end else begin
        op = rme_pkg::OP_W'($urandom_range(rme_pkg::OP_ADD, rme_pkg::OP_SETC));
      end
      send_instr(op, 4'($urandom_range(0, 15)),
                 (op == rme_pkg::OP_SETC) ? $urandom() : pick_operand());
    end

    // Let every owed result arrive, then watch for strays.
    no_idle = 1'b0;
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
